[sv/qalu_pkg.sv]
// ----------------------------------------------------------------------------
// qalu_pkg
// Shared types and constants for the saturating fixed-point quaternion ALU.
// ----------------------------------------------------------------------------
package qalu_pkg;

    // component format
    localparam int COMP_WIDTH = 16;
    localparam int FRAC_BITS  = 12;

    // internal widths
    localparam int PROD_W = 2 * COMP_WIDTH;
    localparam int SUM_W  = PROD_W + 2;
    localparam int LIN_W  = COMP_WIDTH + 1;

    typedef logic signed [COMP_WIDTH-1:0] comp_t;
    typedef logic signed [LIN_W-1:0]      lin_t;
    typedef logic signed [PROD_W-1:0]     prod_t;
    typedef logic signed [SUM_W-1:0]      sum_t;

    // operation codes
    typedef enum logic [1:0] {
        FUNC_ADD  = 2'd0,
        FUNC_SUB  = 2'd1,
        FUNC_MUL  = 2'd2,
        FUNC_CONJ = 2'd3
    } func_t;

    // component limits
    localparam comp_t COMP_HI = {1'b0, {(COMP_WIDTH-1){1'b1}}};
    localparam comp_t COMP_LO = {1'b1, {(COMP_WIDTH-1){1'b0}}};
    localparam sum_t  SAT_HI  = sum_t'(COMP_HI);
    localparam sum_t  SAT_LO  = sum_t'(COMP_LO);

    // half an lsb of the result, for round to nearest
    localparam sum_t ROUND_HALF = sum_t'(64'sd1 <<< (FRAC_BITS - 1));

    // request payload
    typedef struct packed {
        func_t func;
        comp_t a_x;
        comp_t a_y;
        comp_t a_z;
        comp_t a_w;
        comp_t b_x;
        comp_t b_y;
        comp_t b_z;
        comp_t b_w;
    } req_t;

    // result payload
    typedef struct packed {
        comp_t r_x;
        comp_t r_y;
        comp_t r_z;
        comp_t r_w;
        logic  overflow;
    } res_t;

    // four partial products of one product component
    typedef struct packed {
        prod_t p0;
        prod_t p1;
        prod_t p2;
        prod_t p3;
    } term4_t;

    // after the multiply stage
    typedef struct packed {
        func_t  func;
        lin_t   lin_x;
        lin_t   lin_y;
        lin_t   lin_z;
        lin_t   lin_w;
        term4_t t_x;
        term4_t t_y;
        term4_t t_z;
        term4_t t_w;
    } s1_t;

    // after the sum stage
    typedef struct packed {
        func_t func;
        lin_t  lin_x;
        lin_t  lin_y;
        lin_t  lin_z;
        lin_t  lin_w;
        sum_t  sum_x;
        sum_t  sum_y;
        sum_t  sum_z;
        sum_t  sum_w;
    } s2_t;

endpackage

[sv/quaternion_alu_core.sv]
// ----------------------------------------------------------------------------
// quaternion_alu_core: saturating Q4.12 quaternion add, subtract, product, conjugate
// Registered multiply, sum and round/clamp stages; one request per cycle unless the output stalls.
// Each stage holds while stalled and loads when empty or draining, so no bubbles.
// Reset clears the stage valid bits only; the data registers are not reset.
// ----------------------------------------------------------------------------
module quaternion_alu_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  qalu_pkg::req_t  req,
    output logic            res_valid,
    input  logic            res_ready,
    output qalu_pkg::res_t  res
);
    import qalu_pkg::*;

    logic s1_valid;
    logic s1_ready;
    s1_t  s1_data;
    logic s2_valid;
    logic s2_ready;
    s2_t  s2_data;

    // partial products
    qalu_mul u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req_valid),
        .in_ready  (req_ready),
        .in_data   (req),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_data  (s1_data)
    );

    // product sums
    qalu_sum u_sum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_data  (s2_data)
    );

    // rounding, selection and clamping
    qalu_sat u_sat (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_data   (s2_data),
        .out_valid (res_valid),
        .out_ready (res_ready),
        .out_data  (res)
    );

`ifndef NO_ASSERTIONS
    // back-pressure at the input only when every stage is full and the output stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> (s1_valid && s2_valid && res_valid && !res_ready))
        else $error("input stalled while pipeline has a free stage");

    // a request reaches the output through the multiply, sum and round/clamp registers when the output drains
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) ##1 res_ready ##1 res_ready |=> res_valid)
        else $error("request did not reach the output in time");

    // overflow only with a component clamped to a limit
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.overflow) |->
            (res.r_x == COMP_HI || res.r_x == COMP_LO ||
             res.r_y == COMP_HI || res.r_y == COMP_LO ||
             res.r_z == COMP_HI || res.r_z == COMP_LO ||
             res.r_w == COMP_HI || res.r_w == COMP_LO))
        else $error("overflow flagged without a clamped component");
`endif

endmodule

[sv/qalu_mul.sv]
// ----------------------------------------------------------------------------
// qalu_mul
// Stage 1: sixteen partial products of the Hamilton product and the
// add, subtract and conjugate results, registered.
// ----------------------------------------------------------------------------
module qalu_mul (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  qalu_pkg::req_t  in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output qalu_pkg::s1_t   out_data
);
    import qalu_pkg::*;

    logic valid_reg;
    s1_t  data_reg;
    s1_t  data_next;

    // stage can load when empty or when its content moves on
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // partial products and linear results
    always_comb
    begin
        data_next.func = in_data.func;

        data_next.t_x.p0 = prod_t'(in_data.a_w) * prod_t'(in_data.b_x);
        data_next.t_x.p1 = prod_t'(in_data.b_w) * prod_t'(in_data.a_x);
        data_next.t_x.p2 = prod_t'(in_data.a_y) * prod_t'(in_data.b_z);
        data_next.t_x.p3 = prod_t'(in_data.a_z) * prod_t'(in_data.b_y);

        data_next.t_y.p0 = prod_t'(in_data.a_w) * prod_t'(in_data.b_y);
        data_next.t_y.p1 = prod_t'(in_data.b_w) * prod_t'(in_data.a_y);
        data_next.t_y.p2 = prod_t'(in_data.a_z) * prod_t'(in_data.b_x);
        data_next.t_y.p3 = prod_t'(in_data.a_x) * prod_t'(in_data.b_z);

        data_next.t_z.p0 = prod_t'(in_data.a_w) * prod_t'(in_data.b_z);
        data_next.t_z.p1 = prod_t'(in_data.b_w) * prod_t'(in_data.a_z);
        data_next.t_z.p2 = prod_t'(in_data.a_x) * prod_t'(in_data.b_y);
        data_next.t_z.p3 = prod_t'(in_data.a_y) * prod_t'(in_data.b_x);

        data_next.t_w.p0 = prod_t'(in_data.a_w) * prod_t'(in_data.b_w);
        data_next.t_w.p1 = prod_t'(in_data.a_x) * prod_t'(in_data.b_x);
        data_next.t_w.p2 = prod_t'(in_data.a_y) * prod_t'(in_data.b_y);
        data_next.t_w.p3 = prod_t'(in_data.a_z) * prod_t'(in_data.b_z);

        case (in_data.func)
            FUNC_ADD:
            begin
                data_next.lin_x = lin_t'(in_data.a_x) + lin_t'(in_data.b_x);
                data_next.lin_y = lin_t'(in_data.a_y) + lin_t'(in_data.b_y);
                data_next.lin_z = lin_t'(in_data.a_z) + lin_t'(in_data.b_z);
                data_next.lin_w = lin_t'(in_data.a_w) + lin_t'(in_data.b_w);
            end
            FUNC_SUB:
            begin
                data_next.lin_x = lin_t'(in_data.a_x) - lin_t'(in_data.b_x);
                data_next.lin_y = lin_t'(in_data.a_y) - lin_t'(in_data.b_y);
                data_next.lin_z = lin_t'(in_data.a_z) - lin_t'(in_data.b_z);
                data_next.lin_w = lin_t'(in_data.a_w) - lin_t'(in_data.b_w);
            end
            FUNC_CONJ:
            begin
                data_next.lin_x = -lin_t'(in_data.a_x);
                data_next.lin_y = -lin_t'(in_data.a_y);
                data_next.lin_z = -lin_t'(in_data.a_z);
                data_next.lin_w = lin_t'(in_data.a_w);
            end
            default:
            begin
                data_next.lin_x = '0;
                data_next.lin_y = '0;
                data_next.lin_z = '0;
                data_next.lin_w = '0;
            end
        endcase
    end

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // stage data
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

[sv/qalu_sum.sv]
// ----------------------------------------------------------------------------
// qalu_sum
// Stage 2: exact signed sum of the four partial products of each product
// component, plus half an lsb for rounding, registered.
// ----------------------------------------------------------------------------
module qalu_sum (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  qalu_pkg::s1_t   in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output qalu_pkg::s2_t   out_data
);
    import qalu_pkg::*;

    logic valid_reg;
    s2_t  data_reg;
    s2_t  data_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // signed sums, cross term subtracted for the vector part
    always_comb
    begin
        data_next.func  = in_data.func;
        data_next.lin_x = in_data.lin_x;
        data_next.lin_y = in_data.lin_y;
        data_next.lin_z = in_data.lin_z;
        data_next.lin_w = in_data.lin_w;

        data_next.sum_x = sum_t'(in_data.t_x.p0) + sum_t'(in_data.t_x.p1)
                        + sum_t'(in_data.t_x.p2) - sum_t'(in_data.t_x.p3) + ROUND_HALF;
        data_next.sum_y = sum_t'(in_data.t_y.p0) + sum_t'(in_data.t_y.p1)
                        + sum_t'(in_data.t_y.p2) - sum_t'(in_data.t_y.p3) + ROUND_HALF;
        data_next.sum_z = sum_t'(in_data.t_z.p0) + sum_t'(in_data.t_z.p1)
                        + sum_t'(in_data.t_z.p2) - sum_t'(in_data.t_z.p3) + ROUND_HALF;
        // scalar part: a_w*b_w minus the dot product
        data_next.sum_w = sum_t'(in_data.t_w.p0) - sum_t'(in_data.t_w.p1)
                        - sum_t'(in_data.t_w.p2) - sum_t'(in_data.t_w.p3) + ROUND_HALF;
    end

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // stage data
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

[sv/qalu_sat.sv]
// ----------------------------------------------------------------------------
// qalu_sat
// Stage 3: drops the fraction bits of the product sums, picks the result
// for the operation, clamps each component and flags saturation.
// ----------------------------------------------------------------------------
module qalu_sat (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  qalu_pkg::s2_t   in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output qalu_pkg::res_t  out_data
);
    import qalu_pkg::*;

    typedef struct packed {
        comp_t value;
        logic  hit;
    } sat_t;

    logic valid_reg;
    res_t data_reg;
    res_t data_next;
    sum_t pre_x;
    sum_t pre_y;
    sum_t pre_z;
    sum_t pre_w;
    sat_t sat_x;
    sat_t sat_y;
    sat_t sat_z;
    sat_t sat_w;

    // clamp to the component range
    function automatic sat_t saturate(input sum_t v);
        sat_t r;
        if (v > SAT_HI)
        begin
            r.value = COMP_HI;
            r.hit   = 1'b1;
        end
        else if (v < SAT_LO)
        begin
            r.value = COMP_LO;
            r.hit   = 1'b1;
        end
        else
        begin
            r.value = v[COMP_WIDTH-1:0];
            r.hit   = 1'b0;
        end
        return r;
    endfunction

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // result before clamping
    always_comb
    begin
        case (in_data.func)
            FUNC_MUL:
            begin
                pre_x = in_data.sum_x >>> FRAC_BITS;
                pre_y = in_data.sum_y >>> FRAC_BITS;
                pre_z = in_data.sum_z >>> FRAC_BITS;
                pre_w = in_data.sum_w >>> FRAC_BITS;
            end
            default:
            begin
                pre_x = sum_t'(in_data.lin_x);
                pre_y = sum_t'(in_data.lin_y);
                pre_z = sum_t'(in_data.lin_z);
                pre_w = sum_t'(in_data.lin_w);
            end
        endcase
    end

    // clamp and flag
    always_comb
    begin
        sat_x = saturate(pre_x);
        sat_y = saturate(pre_y);
        sat_z = saturate(pre_z);
        sat_w = saturate(pre_w);
        data_next.r_x      = sat_x.value;
        data_next.r_y      = sat_y.value;
        data_next.r_z      = sat_z.value;
        data_next.r_w      = sat_w.value;
        data_next.overflow = sat_x.hit | sat_y.hit | sat_z.hit | sat_w.hit;
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // output data
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule
